@@ rtl/csr_pattern_table_engine_defines.svh @@
// Assertion macros for the pattern table checker
`ifndef CSR_PATTERN_TABLE_ENGINE_DEFINES_SVH
`define CSR_PATTERN_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication on the checker clock, muted during reset
`define CSPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the checker clock, muted during reset
`define CSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cspt_pkg.sv @@
// Constants, codes and item types of the sparse row pattern engine
`timescale 1ns / 1ps
`default_nettype none
package cspt_pkg;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_ENTRIES = 1024;
    localparam int INIT_SLOTS  = 4;
    localparam int INDEX_BITS  = 16;

    localparam int KIND_W = 3;
    localparam int ROW_W  = 16;
    localparam int CNT_W  = 11;
    localparam int POS_W  = 10;
    localparam int ST_W   = 2;
    localparam int OFS_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SA_W   = $clog2(MAX_ENTRIES);
    localparam int OA_W   = $clog2(MAX_ROWS + 1);
    localparam int LR_W   = 7;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [KIND_W-1:0] KIND_INIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESIZE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [ST_W-1:0] ST_CAPACITY = 2'd2;
    localparam logic [ST_W-1:0] ST_POSITION = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_BASE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 1'd1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] column_index;
        logic [POS_W-1:0]      position;
        logic [CNT_W-1:0]      count;
        logic [ROW_W-1:0]      row;
        logic [KIND_W-1:0]     kind;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]      total_count;
        logic [CNT_W-1:0]      row_count;
        logic [INDEX_BITS-1:0] column_out;
        logic                  found;
        logic [ST_W-1:0]       status;
    } result_t;
endpackage
`default_nettype wire

@@ rtl/cspt_ram.sv @@
// Simple dual-port RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module cspt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/cspt_alu.sv @@
// Shared add/subtract unit for row lengths and offset updates
`timescale 1ns / 1ps
`default_nettype none
module cspt_alu (
    input  wire logic [cspt_pkg::OFS_W-1:0] a,
    input  wire logic [cspt_pkg::OFS_W-1:0] b,
    input  wire logic                       sub,
    output logic      [cspt_pkg::OFS_W-1:0] y
);
    import cspt_pkg::*;

    assign y = sub ? (a - b) : (a + b);
endmodule
`default_nettype wire

@@ rtl/cspt_seq.sv @@
// Operation sequencer: walks the column store and offset table per item
`timescale 1ns / 1ps
`default_nettype none
module cspt_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire cspt_pkg::item_t             item,
    input  wire logic [cspt_pkg::ROW_W-1:0]  row_base,
    input  wire logic [cspt_pkg::LR_W-1:0]   local_row_count,
    input  wire logic                        out_free,
    output logic                             idle,
    output logic                             done,
    output cspt_pkg::result_t                res
);
    import cspt_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000000000000001,
        S_CHK  = 16'b0000000000000010,
        S_INIT = 16'b0000000000000100,
        S_OFA  = 16'b0000000000001000,
        S_OFB  = 16'b0000000000010000,
        S_OFC  = 16'b0000000000100000,
        S_DISP = 16'b0000000001000000,
        S_RDW  = 16'b0000000010000000,
        S_SCA  = 16'b0000000100000000,
        S_SCB  = 16'b0000001000000000,
        S_MVR  = 16'b0000010000000000,
        S_MVW  = 16'b0000100000000000,
        S_OFR  = 16'b0001000000000000,
        S_OFW  = 16'b0010000000000000,
        S_FIN  = 16'b0100000000000000,
        S_ZF   = 16'b1000000000000000
    } state_t;

    state_t                state_reg, state_next;
    item_t                 item_reg;
    logic [ROW_W-1:0]      local_reg, local_next;
    logic                  inside_reg, inside_next;
    logic [OFS_W-1:0]      start_reg, start_next;
    logic [OFS_W-1:0]      end_reg, end_next;
    logic [OFS_W-1:0]      len_reg, len_next;
    logic [OFS_W-1:0]      d_reg, d_next;
    logic                  grow_reg, grow_next;
    logic [OFS_W-1:0]      ptr_reg, ptr_next;
    logic [OA_W-1:0]       oi_reg, oi_next;
    logic [LR_W-1:0]       slice_reg, slice_next;
    logic [OFS_W-1:0]      total_reg, total_next;
    logic [OFS_W-1:0]      hw_reg, hw_next;
    logic [ST_W-1:0]       status_reg, status_next;
    logic                  found_reg, found_next;
    logic [INDEX_BITS-1:0] colout_reg, colout_next;

    logic                  s_we;
    logic [SA_W-1:0]       s_waddr, s_raddr;
    logic [INDEX_BITS-1:0] s_wdata, s_rdata, s_data;
    logic                  o_we;
    logic [OA_W-1:0]       o_waddr, o_raddr;
    logic [OFS_W-1:0]      o_wdata, o_rdata;
    logic [OFS_W-1:0]      alu_a, alu_b, alu_y;
    logic                  alu_sub;

    logic [LR_W-1:0]       n_cap;
    logic [OFS_W-1:0]      init_total;
    logic                  init_over;
    logic [OFS_W-1:0]      pos_ext, rw_addr;
    logic [OFS_W:0]        grown;

    cspt_ram #(.WIDTH(INDEX_BITS), .DEPTH(MAX_ENTRIES), .AW(SA_W)) u_store (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    cspt_ram #(.WIDTH(OFS_W), .DEPTH(MAX_ROWS + 1), .AW(OA_W)) u_offs (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    cspt_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

    assign n_cap = (local_row_count > LR_W'(MAX_ROWS)) ? LR_W'(MAX_ROWS) : local_row_count;
    assign init_total = OFS_W'(n_cap) * OFS_W'(INIT_SLOTS);
    assign init_over  = (32'(n_cap) * INIT_SLOTS) > MAX_ENTRIES;
    assign pos_ext    = OFS_W'(item_reg.position);
    assign rw_addr    = start_reg + pos_ext;
    assign grown      = {1'b0, total_reg} + {1'b0, d_reg};
    // Entries at or above the high-water mark were never written since init: read as zero
    assign s_data     = (ptr_reg < hw_reg) ? s_rdata : '0;

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_FIN) && out_free;
    assign res.status      = status_reg;
    assign res.found       = found_reg;
    assign res.column_out  = colout_reg;
    assign res.row_count   = inside_reg ? len_reg : '0;
    assign res.total_count = total_reg;

    always_comb begin
        alu_a   = end_reg;
        alu_b   = start_reg;
        alu_sub = 1'b1;
        if (state_reg == S_OFW) begin
            alu_a   = o_rdata;
            alu_b   = d_reg;
            alu_sub = !grow_reg;
        end
    end

    always_comb begin
        s_we    = 1'b0;
        s_waddr = ptr_reg[SA_W-1:0];
        s_wdata = s_data;
        s_raddr = ptr_reg[SA_W-1:0];
        o_we    = 1'b0;
        o_waddr = oi_reg;
        o_wdata = alu_y;
        o_raddr = oi_reg;
        case (state_reg)
            S_INIT: begin
                s_we    = ptr_reg < init_total;
                s_wdata = (ptr_reg % INIT_SLOTS == 0) ? INDEX_BITS'(ptr_reg / INIT_SLOTS) : '0;
                o_we    = (ptr_reg % INIT_SLOTS == 0);
                o_waddr = OA_W'(ptr_reg / INIT_SLOTS);
                o_wdata = ptr_reg;
            end
            S_OFA: o_raddr = local_reg[OA_W-1:0];
            S_OFB: o_raddr = local_reg[OA_W-1:0] + OA_W'(1);
            S_DISP: begin
                s_we    = (item_reg.kind == KIND_WRITE) && (pos_ext < alu_y);
                s_waddr = rw_addr[SA_W-1:0];
                s_wdata = item_reg.column_index;
                s_raddr = rw_addr[SA_W-1:0];
            end
            S_ZF: begin
                s_we    = hw_reg < grown[OFS_W-1:0];
                s_waddr = hw_reg[SA_W-1:0];
                s_wdata = '0;
            end
            S_MVW: begin
                s_we    = 1'b1;
                s_waddr = grow_reg ? SA_W'(ptr_reg + d_reg) : SA_W'(ptr_reg - d_reg);
            end
            S_OFW: o_we = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        local_next  = local_reg;
        inside_next = inside_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        len_next    = len_reg;
        d_next      = d_reg;
        grow_next   = grow_reg;
        ptr_next    = ptr_reg;
        oi_next     = oi_reg;
        slice_next  = slice_reg;
        total_next  = total_reg;
        hw_next     = hw_reg;
        status_next = status_reg;
        found_next  = found_reg;
        colout_next = colout_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                status_next = ST_OK;
                found_next  = 1'b0;
                colout_next = '0;
                ptr_next    = '0;
                local_next  = item_reg.row - row_base;
                inside_next = (item_reg.row - row_base) < ROW_W'(slice_reg);
                if (item_reg.kind == KIND_INIT && !init_over) begin
                    state_next = S_INIT;
                end else begin
                    if (item_reg.kind == KIND_INIT) begin
                        status_next = ST_CAPACITY;
                    end
                    if ((item_reg.row - row_base) < ROW_W'(slice_reg)) begin
                        state_next = S_OFA;
                    end else begin
                        if (item_reg.kind >= KIND_RESIZE && item_reg.kind <= KIND_CONTAINS) begin
                            status_next = ST_OUTSIDE;
                        end
                        state_next = S_FIN;
                    end
                end
            end
            S_INIT: begin
                if (ptr_reg == init_total) begin
                    slice_next  = n_cap;
                    total_next  = init_total;
                    hw_next     = init_total;
                    len_next    = OFS_W'(INIT_SLOTS);
                    inside_next = local_reg < ROW_W'(n_cap);
                    state_next  = S_FIN;
                end else begin
                    ptr_next = ptr_reg + OFS_W'(1);
                end
            end
            S_OFA: state_next = S_OFB;
            S_OFB: begin
                start_next = o_rdata;
                state_next = S_OFC;
            end
            S_OFC: begin
                end_next   = o_rdata;
                state_next = S_DISP;
            end
            S_DISP: begin
                len_next   = alu_y;
                state_next = S_FIN;
                oi_next    = local_reg[OA_W-1:0] + OA_W'(1);
                case (item_reg.kind)
                    KIND_WRITE: begin
                        if (pos_ext < alu_y) begin
                            if (rw_addr + OFS_W'(1) > hw_reg) begin
                                hw_next = rw_addr + OFS_W'(1);
                            end
                        end else begin
                            status_next = ST_POSITION;
                        end
                    end
                    KIND_READ: begin
                        if (pos_ext < alu_y) begin
                            ptr_next   = rw_addr;
                            state_next = S_RDW;
                        end else begin
                            status_next = ST_POSITION;
                        end
                    end
                    KIND_CONTAINS: begin
                        ptr_next = start_reg;
                        if (start_reg < end_reg) begin
                            state_next = S_SCA;
                        end
                    end
                    KIND_RESIZE: begin
                        if (item_reg.count < alu_y) begin
                            d_next    = alu_y - item_reg.count;
                            grow_next = 1'b0;
                            ptr_next  = start_reg + (alu_y - item_reg.count);
                            state_next = (start_reg + (alu_y - item_reg.count) < total_reg)
                                       ? S_MVR : S_OFR;
                        end else if (item_reg.count > alu_y) begin
                            d_next    = item_reg.count - alu_y;
                            grow_next = 1'b1;
                            if ({1'b0, total_reg} + {1'b0, item_reg.count - alu_y}
                                    > (OFS_W + 1)'(MAX_ENTRIES)) begin
                                status_next = ST_CAPACITY;
                            end else begin
                                ptr_next   = total_reg - OFS_W'(1);
                                state_next = S_ZF;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // zero the entries a growth exposes above the high-water mark, then move any tail entries
            S_ZF: begin
                if (hw_reg < grown[OFS_W-1:0]) begin
                    hw_next = hw_reg + OFS_W'(1);
                end else begin
                    state_next = (total_reg > start_reg) ? S_MVR : S_OFR;
                end
            end
            S_RDW: begin
                found_next  = 1'b1;
                colout_next = s_data;
                state_next  = S_FIN;
            end
            S_SCA: state_next = S_SCB;
            S_SCB: begin
                if (s_data == item_reg.column_index) begin
                    found_next = 1'b1;
                    state_next = S_FIN;
                end else if (ptr_reg + OFS_W'(1) < end_reg) begin
                    ptr_next   = ptr_reg + OFS_W'(1);
                    state_next = S_SCA;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_MVR: state_next = S_MVW;
            S_MVW: begin
                // grow moves from the top down, shrink from the bottom up
                if (grow_reg) begin
                    if (ptr_reg == start_reg) begin
                        state_next = S_OFR;
                    end else begin
                        ptr_next   = ptr_reg - OFS_W'(1);
                        state_next = S_MVR;
                    end
                end else if (ptr_reg + OFS_W'(1) < total_reg) begin
                    ptr_next   = ptr_reg + OFS_W'(1);
                    state_next = S_MVR;
                end else begin
                    state_next = S_OFR;
                end
            end
            S_OFR: state_next = S_OFW;
            S_OFW: begin
                if (OFS_W'(oi_reg) == OFS_W'(slice_reg)) begin
                    if (grow_reg) begin
                        total_next = grown[OFS_W-1:0];
                        if (grown[OFS_W-1:0] > hw_reg) begin
                            hw_next = grown[OFS_W-1:0];
                        end
                    end else begin
                        total_next = total_reg - d_reg;
                    end
                    len_next   = item_reg.count;
                    state_next = S_FIN;
                end else begin
                    oi_next    = oi_reg + OA_W'(1);
                    state_next = S_OFR;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            slice_reg  <= '0;
            total_reg  <= '0;
            hw_reg     <= '0;
            inside_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            slice_reg  <= slice_next;
            total_reg  <= total_next;
            hw_reg     <= hw_next;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == S_IDLE) begin
            item_reg <= item;
        end
        local_reg  <= local_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        len_reg    <= len_next;
        d_reg      <= d_next;
        grow_reg   <= grow_next;
        ptr_reg    <= ptr_next;
        oi_reg     <= oi_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        colout_reg <= colout_next;
    end
endmodule
`default_nettype wire

@@ rtl/csr_pattern_table_engine.sv @@
// Top level: stream ports, configuration registers and result register
//
// Compressed-row sparsity pattern engine for a slice of up to 64 rows and
// 1024 column entries. One item is processed at a time by a sequencer that
// drives one column-store RAM port pair and one offset-table RAM port pair.
// A contains scans the row's entries. A resize shifts the stored entries from
// the row onward and updates the offsets from the next row to the end of the
// slice; a growth first zeroes the entries exposed above the high-water mark.
// Init writes the slots of each row and the row offsets. The store needs no
// clearing pass: a high-water mark makes never-written entries read as zero,
// and a growth past the mark zeroes the exposed entries first. A new item is
// taken once the previous result is in the output register.
`timescale 1ns / 1ps
`default_nettype none
module csr_pattern_table_engine (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // row[15:0], count[26:16], position[36:27], column_index[52:37]
    input  wire logic [cspt_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind[2:0]
    input  wire logic [cspt_pkg::KIND_W-1:0]          s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // status[1:0], found[2], column_out[18:3], row_count[29:19], total_count[40:30]
    output logic [cspt_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [cspt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [cspt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import cspt_pkg::*;

    logic [ROW_W-1:0]  row_base_reg;
    logic [LR_W-1:0]   row_count_reg;
    logic              m_tvalid_reg;
    result_t           res_reg;
    result_t           res;
    item_t             item;
    logic              idle, done, out_free;

    assign item.kind         = s_tuser;
    assign item.row          = s_tdata[15:0];
    assign item.count        = s_tdata[26:16];
    assign item.position     = s_tdata[36:27];
    assign item.column_index = s_tdata[52:37];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), res_reg};

    cspt_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(s_tvalid), .item(item),
        .row_base(row_base_reg), .local_row_count(row_count_reg),
        .out_free(out_free), .idle(idle), .done(done), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_base_reg  <= '0;
            row_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == REG_ROW_BASE) begin
                row_base_reg <= cfg_wdata[ROW_W-1:0];
            end
            if (cfg_we && cfg_addr == REG_ROW_COUNT) begin
                row_count_reg <= cfg_wdata[LR_W-1:0];
            end
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            res_reg <= res;
        end
    end
endmodule
`default_nettype wire

@@ rtl/cspt_checker.sv @@
// Port-level checks for the pattern table engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "csr_pattern_table_engine_defines.svh"
module cspt_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [cspt_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import cspt_pkg::*;

    `CSPT_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after item taken")
    `CSPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `CSPT_ASSERT_SAME(a_outside_zero, m_tvalid && m_tdata[1:0] == ST_OUTSIDE, m_tdata[29:19] == '0, "outside row has length")
    `CSPT_ASSERT_SAME(a_found_ok, m_tvalid && m_tdata[2], m_tdata[1:0] == ST_OK, "found with error status")
    `CSPT_ASSERT_SAME(a_total_cap, m_tvalid, m_tdata[40:30] <= 11'(MAX_ENTRIES), "total above capacity")
endmodule

bind csr_pattern_table_engine cspt_checker u_cspt_checker (.*);
`default_nettype wire

@@ bench/tb_csr_pattern_table_engine.sv @@
// Self-checking bench for the sparse row pattern engine
`timescale 1ns / 1ps
`default_nettype none
module tb_csr_pattern_table_engine;
    import cspt_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    csr_pattern_table_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // shadow of the pattern
    logic [15:0] col_mem [MAX_ENTRIES];
    logic [10:0] ofs_mem [MAX_ROWS+1];
    int unsigned slice_rows;
    logic [15:0] base_reg;
    logic [6:0]  rows_reg;

    result_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;

    initial forever #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic result_t predict_pattern_op(item_t it);
        result_t r;
        int unsigned rel_row, n, total, old_len, start, d, cnt, pos;
        logic in_slice;
        r = '0;
        rel_row = 16'(it.row - base_reg);
        cnt = it.count;
        pos = it.position;
        if (it.kind == KIND_INIT) begin
            n = (rows_reg < MAX_ROWS) ? rows_reg : MAX_ROWS;
            if (n * INIT_SLOTS > MAX_ENTRIES) r.status = ST_CAPACITY;
            else begin
                foreach (col_mem[i]) col_mem[i] = '0;
                foreach (ofs_mem[i]) ofs_mem[i] = '0;
                for (int i = 0; i < n; i++) begin
                    col_mem[i*INIT_SLOTS] = 16'(i);
                    ofs_mem[i+1] = ofs_mem[i] + INIT_SLOTS;
                end
                slice_rows = n;
            end
        end
        in_slice = rel_row < slice_rows;
        if (it.kind >= KIND_RESIZE && it.kind <= KIND_CONTAINS && !in_slice) begin
            r.status = ST_OUTSIDE;
        end else if (it.kind == KIND_RESIZE) begin
            total = ofs_mem[slice_rows];
            start = ofs_mem[rel_row];
            old_len = ofs_mem[rel_row+1] - start;
            if (cnt < old_len) begin
                d = old_len - cnt;
                for (int i = start; i < total - d; i++) col_mem[i] = col_mem[i+d];
                for (int i = rel_row + 1; i <= slice_rows; i++) ofs_mem[i] -= d;
            end else if (cnt > old_len) begin
                d = cnt - old_len;
                if (total + d > MAX_ENTRIES) r.status = ST_CAPACITY;
                else begin
                    for (int i = total - 1; i >= int'(start); i--) col_mem[i+d] = col_mem[i];
                    for (int i = rel_row + 1; i <= slice_rows; i++) ofs_mem[i] += d;
                end
            end
        end else if (it.kind == KIND_WRITE) begin
            if (pos < ofs_mem[rel_row+1] - ofs_mem[rel_row])
                col_mem[ofs_mem[rel_row] + pos] = it.column_index;
            else r.status = ST_POSITION;
        end else if (it.kind == KIND_READ) begin
            if (pos < ofs_mem[rel_row+1] - ofs_mem[rel_row]) begin
                r.found = 1'b1;
                r.column_out = col_mem[ofs_mem[rel_row] + pos];
            end else r.status = ST_POSITION;
        end else if (it.kind == KIND_CONTAINS) begin
            for (int i = ofs_mem[rel_row]; i < ofs_mem[rel_row+1]; i++)
                if (col_mem[i] == it.column_index) r.found = 1'b1;
        end
        r.row_count = in_slice ? 11'(ofs_mem[rel_row+1] - ofs_mem[rel_row]) : '0;
        r.total_count = 11'(ofs_mem[slice_rows]);
        return r;
    endfunction

    // burst sender: random gaps between bursts
    int burst_left = 0;
    task automatic send_op(logic [KIND_W-1:0] kind, logic [15:0] row,
                           logic [10:0] count, logic [9:0] pos, logic [15:0] col);
        item_t it;
        int gap;
        it = '{column_index: col, position: pos, count: count, row: row, kind: kind};
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, it.column_index, it.position, it.count, it.row};
        s_tuser <= it.kind;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_pattern_op(it));
    endtask

    // receiver stalls on a rotating pattern, with quiet stretches
    logic [15:0] stall_pattern = 16'hA5C3;
    always @(posedge aclk) begin
        stall_pattern <= {stall_pattern[14:0], stall_pattern[15] ^ stall_pattern[13]};
        m_tready <= (cycles % 3000 < 800) ? 1'b1 : stall_pattern[0] | stall_pattern[3];
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[40:0]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d f=%0d c=%h rc=%0d tc=%0d, got st=%0d f=%0d c=%h rc=%0d tc=%0d",
                            want.status, want.found, want.column_out, want.row_count,
                            want.total_count, got.status, got.found, got.column_out,
                            got.row_count, got.total_count);
                end
            end
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_ROW_BASE) base_reg = val;
        else rows_reg = val[6:0];
        @(posedge aclk);
    endtask

    task automatic set_slice(logic [15:0] b, logic [6:0] n);
        drain();
        write_reg(REG_ROW_BASE, b);
        write_reg(REG_ROW_COUNT, n);
    endtask

    task automatic test_directed();
        send_op(KIND_READ, 16'h0, 11'd0, 10'd0, 16'h0);      // empty slice
        set_slice(16'hFFFE, 7'd64);
        send_op(KIND_INIT, 16'hFFFF, 11'd0, 10'd0, 16'h0);
        send_op(KIND_READ, 16'h003D, 11'd0, 10'd0, 16'h0);   // wraps to last row
        send_op(KIND_WRITE, 16'hFFFE, 11'd0, 10'd3, 16'hFFFF);
        send_op(KIND_CONTAINS, 16'hFFFE, 11'd0, 10'd0, 16'hFFFF);
        send_op(KIND_READ, 16'hFFFE, 11'd0, 10'd4, 16'h0);   // outside row
        send_op(KIND_WRITE, 16'hFFFE, 11'd0, 10'd1023, 16'h1);
        send_op(KIND_READ, 16'h003E, 11'd0, 10'd0, 16'h0);   // outside slice
        send_op(KIND_RESIZE, 16'hFFFE, 11'd1024, 10'd0, 16'h0); // capacity
        send_op(KIND_RESIZE, 16'hFFFE, 11'd0, 10'd0, 16'h0);
        send_op(KIND_RESIZE, 16'hFFFF, 11'd7, 10'd0, 16'h0); // grow at front
        send_op(KIND_READ, 16'hFFFF, 11'd0, 10'd6, 16'h0);
        send_op(KIND_RESIZE, 16'h0000, 11'd2, 10'd0, 16'h0); // shrink keeps tail
        send_op(KIND_CONTAINS, 16'h0005, 11'd0, 10'd0, 16'h0);
        send_op(3'd5, 16'h0, 11'd0, 10'd0, 16'h0);
        send_op(3'd7, 16'hFFFF, 11'h7FF, 10'h3FF, 16'hFFFF);
        set_slice(16'h0000, 7'd127);                         // too many rows
        send_op(KIND_INIT, 16'h0, 11'd0, 10'd0, 16'h0);
        set_slice(16'h1234, 7'd1);
        send_op(KIND_INIT, 16'h1234, 11'd0, 10'd0, 16'h0);
        send_op(KIND_RESIZE, 16'h1234, 11'd1024, 10'd0, 16'h0);
        send_op(KIND_WRITE, 16'h1234, 11'd0, 10'd1023, 16'hA5A5);
        send_op(KIND_READ, 16'h1234, 11'd0, 10'd1023, 16'h0);
        send_op(KIND_CONTAINS, 16'h1234, 11'd0, 10'd0, 16'h5A5A);
    endtask

    task automatic test_random(int n_items);
        logic [2:0] kind;
        logic [15:0] row;
        int sel;
        for (int i = 0; i < n_items; i++) begin
            if (i % 400 == 0) begin
                sel = $urandom_range(0, 3);
                set_slice(sel == 0 ? 16'($urandom) : 16'($urandom_range(0, 100)),
                          sel == 1 ? 7'd64 : 7'($urandom_range(0, 70)));
                send_op(KIND_INIT, 16'($urandom), 11'($urandom), 10'($urandom), 16'($urandom));
            end
            sel = $urandom_range(0, 99);
            if (sel < 3) kind = 3'($urandom_range(5, 7));
            else if (sel < 5) kind = KIND_INIT;
            else kind = 3'($urandom_range(1, 4));
            row = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                  : 16'(base_reg + $urandom_range(0, (slice_rows > 0) ? slice_rows - 1 : 0));
            send_op(kind, row,
                    ($urandom_range(0, 19) == 0) ? 11'($urandom) : 11'($urandom_range(0, 12)),
                    ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8)),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70)));
        end
    endtask

    initial begin
        foreach (col_mem[i]) col_mem[i] = '0;
        foreach (ofs_mem[i]) ofs_mem[i] = '0;
        slice_rows = 0;
        base_reg = '0;
        rows_reg = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(2000);
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
